/* design/agt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agt_pkg
// Shared types, constants and helper functions of the adjacency matrix
// graph traversal block.
// ----------------------------------------------------------------------------
package agt_pkg;

	localparam int VERTEX_W           = 6;
	localparam int ROW_W              = 64;
	localparam int CFG_W              = 7;
	localparam int REQ_W              = 3;
	localparam int MAX_VERTEX_DEFAULT = 64;

	localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd64;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD_EDGE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DFS      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_BFS      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
	} request_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] visited_vertex;
		logic                last_vertex;
	} result_t;

	// memory requests from the sequencer
	typedef struct packed {
		logic                adj_we;
		logic [VERTEX_W-1:0] adj_waddr;
		logic [ROW_W-1:0]    adj_wdata;
		logic [VERTEX_W-1:0] adj_raddr;
		logic                stk_we;
		logic [VERTEX_W-1:0] stk_waddr;
		logic [VERTEX_W-1:0] stk_wdata;
		logic [VERTEX_W-1:0] stk_raddr;
		logic                que_we;
		logic [VERTEX_W-1:0] que_waddr;
		logic [VERTEX_W-1:0] que_wdata;
		logic [VERTEX_W-1:0] que_raddr;
	} mem_req_t;

	// neighbor search result
	typedef struct packed {
		logic                any;
		logic [VERTEX_W-1:0] index;
		logic [ROW_W-1:0]    cand;
	} scan_res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ADD_RD_A,
		ST_ADD_WR_A,
		ST_ADD_RD_B,
		ST_ADD_WR_B,
		ST_REM_RD,
		ST_REM_WR,
		ST_DFS_ROW_RD,
		ST_DFS_SCAN,
		ST_DFS_POP_RD,
		ST_DFS_POP_LD,
		ST_BFS_POP_RD,
		ST_BFS_POP_LD,
		ST_BFS_ROW_RD,
		ST_BFS_SCAN,
		ST_BFS_PUSH,
		ST_FINISH
	} agt_state_t;

	// bits below the active vertex count
	function automatic logic [ROW_W-1:0] scan_mask(input logic [CFG_W-1:0] n);
		logic [ROW_W-1:0] m;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (CFG_W'(i) < n);
		end
		return m;
	endfunction

	// index of the lowest set bit
	function automatic logic [VERTEX_W-1:0] lowest_bit(input logic [ROW_W-1:0] x);
		logic [VERTEX_W-1:0] idx;
		idx = VERTEX_W'(ROW_W - 1);
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (x[i]) begin
				idx = VERTEX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

/* design/agt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module agt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/agt_scan_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agt_scan_unit
// Shared neighbor search: masks a row with the unvisited, in-range vertices
// and priority encodes the lowest candidate.
// ----------------------------------------------------------------------------
module agt_scan_unit import agt_pkg::*; (
	input  logic [ROW_W-1:0] row,
	input  logic [ROW_W-1:0] visited,
	input  logic [ROW_W-1:0] mask,
	output scan_res_t        res
);

	logic [ROW_W-1:0] cand;

	// candidate set and lowest index
	always_comb begin
		cand      = row & ~visited & mask;
		res.cand  = cand;
		res.any   = |cand;
		res.index = lowest_bit(cand);
	end

endmodule

/* design/agt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agt_ctrl
// Request sequencer: edge updates, vertex removal sweep, and depth-first and
// breadth-first walks over the adjacency RAM using the shared scan unit.
// ----------------------------------------------------------------------------
module agt_ctrl import agt_pkg::*; #(
	parameter int MAX_VERTEX_COUNT = MAX_VERTEX_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  request_t            request,
	input  logic [CFG_W-1:0]    vertex_count,
	output mem_req_t            mem_req,
	input  logic [ROW_W-1:0]    adj_rdata,
	input  logic [VERTEX_W-1:0] stk_rdata,
	input  logic [VERTEX_W-1:0] que_rdata,
	output logic                result_valid,
	output result_t             result
);

	localparam int AW = $clog2(MAX_VERTEX_COUNT);
	localparam int CW = $clog2(MAX_VERTEX_COUNT + 1);
	localparam logic [CFG_W-1:0] MAX_V    = CFG_W'(MAX_VERTEX_COUNT);
	localparam logic [CW-1:0]    LAST_IDX = CW'(MAX_VERTEX_COUNT - 1);

	agt_state_t state_q, state_d;

	logic [VERTEX_W-1:0]         a_q, b_q, cur_q;
	logic [CW-1:0]               sp_q, head_q, tail_q, idx_q;
	logic [ROW_W-1:0]            visited_q, cand_q;
	logic [MAX_VERTEX_COUNT-1:0] row_valid_q;
	logic                        rvalid_q;
	logic                        pend_valid_q;
	logic [VERTEX_W-1:0]         pend_vertex_q;
	logic                        result_valid_q;
	result_t                     result_q;

	logic                accept;
	logic                a_ok, b_ok;
	logic [CFG_W-1:0]    active_n;
	logic [ROW_W-1:0]    mask;
	logic [ROW_W-1:0]    adj_row;
	logic [ROW_W-1:0]    scan_row;
	logic [ROW_W-1:0]    rm_keep;
	scan_res_t           scan;
	logic                emit;
	logic [VERTEX_W-1:0] emit_vertex;
	logic                res_load;
	logic                res_last;

	// request decode and shared terms
	assign accept   = start && (state_q == ST_IDLE);
	assign a_ok     = {1'b0, request.vertex_a} < MAX_V;
	assign b_ok     = {1'b0, request.vertex_b} < MAX_V;
	assign active_n = (vertex_count > MAX_V) ? MAX_V : vertex_count;
	assign mask     = scan_mask(active_n);
	assign adj_row  = rvalid_q ? adj_rdata : '0;
	assign scan_row = (state_q == ST_BFS_PUSH) ? cand_q : adj_row;

	// removal keeps bits outside the cleared column and the cleared row range
	assign rm_keep = ~((((CFG_W'(idx_q) < active_n)) ? (ROW_W'(1) << a_q) : '0)
		| ((VERTEX_W'(idx_q) == a_q) ? mask : '0));

	agt_scan_unit u_scan (
		.row     (scan_row),
		.visited (visited_q),
		.mask    (mask),
		.res     (scan)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (request.req_type)
						REQ_ADD_EDGE: if (a_ok && b_ok) state_d = ST_ADD_RD_A;
						REQ_REMOVE:   if (a_ok) state_d = ST_REM_RD;
						REQ_DFS:      if (a_ok) state_d = ST_DFS_ROW_RD;
						REQ_BFS:      if (a_ok) state_d = ST_BFS_POP_RD;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD_A:   state_d = ST_ADD_WR_A;
			ST_ADD_WR_A:   state_d = ST_ADD_RD_B;
			ST_ADD_RD_B:   state_d = ST_ADD_WR_B;
			ST_ADD_WR_B:   state_d = ST_IDLE;
			ST_REM_RD:     state_d = ST_REM_WR;
			ST_REM_WR:     state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_REM_RD;
			ST_DFS_ROW_RD: state_d = ST_DFS_SCAN;
			ST_DFS_SCAN: begin
				if (scan.any) begin
					state_d = ST_DFS_ROW_RD;
				end else if (sp_q == CW'(1)) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_DFS_POP_RD;
				end
			end
			ST_DFS_POP_RD: state_d = ST_DFS_POP_LD;
			ST_DFS_POP_LD: state_d = ST_DFS_ROW_RD;
			ST_BFS_POP_RD: state_d = ST_BFS_POP_LD;
			ST_BFS_POP_LD: state_d = ST_BFS_ROW_RD;
			ST_BFS_ROW_RD: state_d = ST_BFS_SCAN;
			ST_BFS_SCAN:   state_d = ST_BFS_PUSH;
			ST_BFS_PUSH: begin
				if (scan.any) begin
					state_d = ST_BFS_PUSH;
				end else if (head_q == tail_q) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_BFS_POP_RD;
				end
			end
			ST_FINISH:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// memory requests and emitted vertices
	always_comb begin
		mem_req           = '0;
		mem_req.adj_raddr = cur_q;
		emit              = 1'b0;
		emit_vertex       = scan.index;
		res_last          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && a_ok && request.req_type == REQ_DFS) begin
					mem_req.stk_we    = 1'b1;
					mem_req.stk_wdata = request.vertex_a;
					emit              = 1'b1;
					emit_vertex       = request.vertex_a;
				end
				if (accept && a_ok && request.req_type == REQ_BFS) begin
					mem_req.que_we    = 1'b1;
					mem_req.que_wdata = request.vertex_a;
				end
			end
			ST_ADD_RD_A: mem_req.adj_raddr = a_q;
			ST_ADD_WR_A: begin
				mem_req.adj_we    = 1'b1;
				mem_req.adj_waddr = a_q;
				mem_req.adj_wdata = adj_row | (ROW_W'(1) << b_q);
			end
			ST_ADD_RD_B: mem_req.adj_raddr = b_q;
			ST_ADD_WR_B: begin
				mem_req.adj_we    = 1'b1;
				mem_req.adj_waddr = b_q;
				mem_req.adj_wdata = adj_row | (ROW_W'(1) << a_q);
			end
			ST_REM_RD: mem_req.adj_raddr = VERTEX_W'(idx_q);
			ST_REM_WR: begin
				mem_req.adj_we    = 1'b1;
				mem_req.adj_waddr = VERTEX_W'(idx_q);
				mem_req.adj_wdata = adj_row & rm_keep;
			end
			ST_DFS_SCAN: begin
				if (scan.any) begin
					mem_req.stk_we    = 1'b1;
					mem_req.stk_waddr = VERTEX_W'(sp_q);
					mem_req.stk_wdata = scan.index;
					emit              = 1'b1;
				end
			end
			ST_DFS_POP_RD: mem_req.stk_raddr = VERTEX_W'(sp_q - CW'(1));
			ST_BFS_POP_RD: mem_req.que_raddr = VERTEX_W'(head_q);
			ST_BFS_POP_LD: begin
				emit        = 1'b1;
				emit_vertex = que_rdata;
			end
			ST_BFS_PUSH: begin
				if (scan.any) begin
					mem_req.que_we    = 1'b1;
					mem_req.que_waddr = VERTEX_W'(tail_q);
					mem_req.que_wdata = scan.index;
				end
			end
			ST_FINISH: res_last = 1'b1;
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// a result beat leaves when the next vertex arrives or the walk ends
	assign res_load = (emit && pend_valid_q) || res_last;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			row_valid_q    <= '0;
			pend_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_load;
			if (accept && request.req_type == REQ_CLEAR) begin
				row_valid_q <= '0;
			end else if (mem_req.adj_we) begin
				row_valid_q[mem_req.adj_waddr[AW-1:0]] <= 1'b1;
			end
			if (res_last) begin
				pend_valid_q <= 1'b0;
			end else if (emit) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		rvalid_q <= row_valid_q[mem_req.adj_raddr[AW-1:0]];
		if (res_load) begin
			result_q.visited_vertex <= pend_vertex_q;
			result_q.last_vertex    <= res_last;
		end
		if (emit) begin
			pend_vertex_q <= emit_vertex;
		end
		if (accept) begin
			a_q       <= request.vertex_a;
			b_q       <= request.vertex_b;
			cur_q     <= request.vertex_a;
			sp_q      <= CW'(1);
			head_q    <= '0;
			tail_q    <= CW'(1);
			idx_q     <= '0;
			visited_q <= ROW_W'(1) << request.vertex_a;
		end
		case (state_q)
			ST_REM_WR: idx_q <= idx_q + CW'(1);
			ST_DFS_SCAN: begin
				if (scan.any) begin
					visited_q <= visited_q | (ROW_W'(1) << scan.index);
					cur_q     <= scan.index;
					sp_q      <= sp_q + CW'(1);
				end else begin
					sp_q <= sp_q - CW'(1);
				end
			end
			ST_DFS_POP_LD: cur_q <= stk_rdata;
			ST_BFS_POP_RD: head_q <= head_q + CW'(1);
			ST_BFS_POP_LD: cur_q <= que_rdata;
			ST_BFS_SCAN:   cand_q <= scan.cand;
			ST_BFS_PUSH: begin
				if (scan.any) begin
					visited_q <= visited_q | (ROW_W'(1) << scan.index);
					cand_q    <= cand_q & ~(ROW_W'(1) << scan.index);
					tail_q    <= tail_q + CW'(1);
				end
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* design/adjacency_matrix_graph_traversal.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_traversal
// Undirected graph store in an adjacency bit matrix with depth-first and
// breadth-first walks.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken when start is high and busy is low; busy
// then stays high until the request is done (a clear or a spare request code
// never raises it). Walk requests return one result beat per visited vertex
// on result, marked by result_valid for one cycle; last_vertex flags the
// final beat. The receiver cannot stall, so beats are never held. The vertex
// count register is written through cfg_we/cfg_wdata; the user must write it
// only while busy is low, which the block itself does not enforce.
// Add edge reads and rewrites both endpoint rows; remove vertex sweeps all
// MAX_VERTEX_COUNT rows with one read and one write per row. Walks are paced
// by the single adjacency RAM read port, which feeds one row a pass to the
// shared neighbor search unit. Each beat is sent once the next vertex is
// known, the last one from the finish state after the walk ends: the first
// depth-first beat once a first neighbor of the start vertex is found or the
// walk ends, the first breadth-first beat only after the start vertex's whole neighbor scan.
// Reset clears the graph at once (per-row valid bits), sets the vertex count
// to 64 and leaves the block idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_traversal import agt_pkg::*; #(
	parameter int MAX_VERTEX_COUNT = MAX_VERTEX_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  request_t         request,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             result_valid,
	output result_t          result
);

	localparam int AW = $clog2(MAX_VERTEX_COUNT);

	logic [CFG_W-1:0]    vertex_count_q;
	mem_req_t            mem_req;
	logic [ROW_W-1:0]    adj_rdata;
	logic [VERTEX_W-1:0] stk_rdata;
	logic [VERTEX_W-1:0] que_rdata;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	agt_ctrl #(
		.MAX_VERTEX_COUNT (MAX_VERTEX_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.vertex_count (vertex_count_q),
		.mem_req      (mem_req),
		.adj_rdata    (adj_rdata),
		.stk_rdata    (stk_rdata),
		.que_rdata    (que_rdata),
		.result_valid (result_valid),
		.result       (result)
	);

	// adjacency rows
	agt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_VERTEX_COUNT)
	) u_adj_ram (
		.clk   (clk),
		.we    (mem_req.adj_we),
		.waddr (mem_req.adj_waddr[AW-1:0]),
		.wdata (mem_req.adj_wdata),
		.raddr (mem_req.adj_raddr[AW-1:0]),
		.rdata (adj_rdata)
	);

	// depth-first stack
	agt_ram #(
		.WIDTH (VERTEX_W),
		.DEPTH (MAX_VERTEX_COUNT)
	) u_stk_ram (
		.clk   (clk),
		.we    (mem_req.stk_we),
		.waddr (mem_req.stk_waddr[AW-1:0]),
		.wdata (mem_req.stk_wdata),
		.raddr (mem_req.stk_raddr[AW-1:0]),
		.rdata (stk_rdata)
	);

	// breadth-first queue
	agt_ram #(
		.WIDTH (VERTEX_W),
		.DEPTH (MAX_VERTEX_COUNT)
	) u_que_ram (
		.clk   (clk),
		.we    (mem_req.que_we),
		.waddr (mem_req.que_waddr[AW-1:0]),
		.wdata (mem_req.que_wdata),
		.raddr (mem_req.que_raddr[AW-1:0]),
		.rdata (que_rdata)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add-edge, remove-vertex, clear and walk requests into the graph
// block under several vertex counts, predicts every depth-first and
// breadth-first visit beat from a private copy of the adjacency matrix, and
// checks the visit beats in order as they come out.
// ----------------------------------------------------------------------------
module testbench;
	import agt_pkg::*;

	localparam int  HALF_PERIOD    = 4;
	localparam int  SETTLE_CYCLES  = 140;
	localparam int  DRAIN_CYCLES   = 200;
	localparam int  LIMIT_CYCLES   = 1000000;
	localparam int  PHASE_ITEMS    = 36;
	localparam int  MAX_REPORTS    = 50;

	typedef struct {
		logic             is_setting;
		logic [CFG_W-1:0] count;
		request_t         req;
	} stim_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	request_t         request;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             result_valid;
	result_t          result;

	// stimulus waiting for the driver and visit beats waiting for the design
	stim_t   pending_beats[$];
	result_t expected_visits[$];

	// private copy of the graph and the vertex count register
	logic [ROW_W-1:0] graph_rows [ROW_W];
	logic [CFG_W-1:0] model_count;

	int    sent_cnt;
	int    taken_cnt;
	int    hold_off;
	int    quiet_cycles;
	bit    calm;
	int    errors;
	int    beats_checked;
	int    depth_walks;
	int    breadth_walks;
	int    settings_written;
	int    cycle_count;
	stim_t nxt;
	logic  cfg_we_next;
	logic [CFG_W-1:0] phase_counts [10];

	adjacency_matrix_graph_traversal DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	// clock
	always #(HALF_PERIOD) clk = ~clk;

	// bits below the active vertex count
	function automatic logic [ROW_W-1:0] count_mask(input logic [CFG_W-1:0] n);
		if (n >= CFG_W'(ROW_W)) begin
			return '1;
		end
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int lowest_set(input logic [ROW_W-1:0] x);
		for (int i = 0; i < ROW_W; i++) begin
			if (x[i]) begin
				return i;
			end
		end
		return ROW_W - 1;
	endfunction

	// update the graph copy and queue the visit beats a request causes
	task automatic model_request(input request_t r);
		logic [ROW_W-1:0]    mask;
		logic [ROW_W-1:0]    cand;
		logic [ROW_W-1:0]    seen;
		logic [VERTEX_W-1:0] order[$];
		logic [VERTEX_W-1:0] frontier[$];
		logic [VERTEX_W-1:0] v;
		int                  n;
		int                  j;
		result_t             beat;
		mask = count_mask(model_count);
		n = (model_count > CFG_W'(ROW_W)) ? ROW_W : int'(model_count);
		case (r.req_type)
			REQ_ADD_EDGE: begin
				graph_rows[r.vertex_a][r.vertex_b] = 1'b1;
				graph_rows[r.vertex_b][r.vertex_a] = 1'b1;
			end
			REQ_REMOVE: begin
				// only bits below the vertex count go away
				graph_rows[r.vertex_a] &= ~mask;
				for (int i = 0; i < n; i++) begin
					graph_rows[i][r.vertex_a] = 1'b0;
				end
			end
			REQ_DFS: begin
				depth_walks++;
				seen = 64'd1 << r.vertex_a;
				frontier.push_back(r.vertex_a);
				order.push_back(r.vertex_a);
				while (frontier.size() != 0) begin
					v = frontier[$];
					cand = graph_rows[v] & ~seen & mask;
					if (cand == '0) begin
						void'(frontier.pop_back());
					end else begin
						j = lowest_set(cand);
						seen[j] = 1'b1;
						order.push_back(VERTEX_W'(j));
						frontier.push_back(VERTEX_W'(j));
					end
				end
			end
			REQ_BFS: begin
				breadth_walks++;
				seen = 64'd1 << r.vertex_a;
				frontier.push_back(r.vertex_a);
				while (frontier.size() != 0) begin
					v = frontier.pop_front();
					order.push_back(v);
					for (int i = 0; i < n; i++) begin
						if (graph_rows[v][i] && !seen[i]) begin
							seen[i] = 1'b1;
							frontier.push_back(VERTEX_W'(i));
						end
					end
				end
			end
			REQ_CLEAR: begin
				foreach (graph_rows[i]) begin
					graph_rows[i] = '0;
				end
			end
			default: begin
			end
		endcase
		foreach (order[k]) begin
			beat.visited_vertex = order[k];
			beat.last_vertex = (k == order.size() - 1);
			expected_visits.push_back(beat);
		end
	endtask

	task automatic queue_request(input logic [REQ_W-1:0] kind, input int a, input int b);
		stim_t s;
		s.is_setting = 1'b0;
		s.count = '0;
		s.req.req_type = kind;
		s.req.vertex_a = VERTEX_W'(a);
		s.req.vertex_b = VERTEX_W'(b);
		pending_beats.push_back(s);
	endtask

	task automatic queue_setting(input logic [CFG_W-1:0] value);
		stim_t s;
		s.is_setting = 1'b1;
		s.count = value;
		s.req = '0;
		pending_beats.push_back(s);
	endtask

	// mostly vertices in use, sometimes anywhere in the index range
	function automatic int pick_vertex(input logic [CFG_W-1:0] n);
		if (n == '0 || n > CFG_W'(ROW_W) || $urandom_range(0, 4) == 0) begin
			return $urandom_range(0, ROW_W - 1);
		end
		return $urandom_range(0, int'(n) - 1);
	endfunction

	// driver: request and register beats change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			cfg_we_next = 1'b0;
			if (!(start && taken_cnt != sent_cnt)) begin
				if (hold_off != 0) begin
					start <= 1'b0;
					hold_off--;
				end else if (pending_beats.size() == 0) begin
					start <= 1'b0;
				end else if (pending_beats[0].is_setting) begin
					// register writes only once the block has gone quiet
					start <= 1'b0;
					if (busy || expected_visits.size() != 0) begin
						quiet_cycles = 0;
					end else if (quiet_cycles < SETTLE_CYCLES) begin
						quiet_cycles++;
					end else begin
						nxt = pending_beats.pop_front();
						cfg_we_next = 1'b1;
						cfg_wdata <= nxt.count;
						quiet_cycles = 0;
					end
				end else begin
					nxt = pending_beats.pop_front();
					request <= nxt.req;
					start <= 1'b1;
					sent_cnt++;
					if ($urandom_range(0, 15) == 0) begin
						calm = !calm;
					end
					hold_off = calm ? 0 : $urandom_range(0, 3);
				end
			end
			cfg_we <= cfg_we_next;
		end
	end

	// monitor: check visit beats, then take in register and request beats
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_visits.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: unexpected visit beat, expected none, got vertex %0d last %0b",
							$time, result.visited_vertex, result.last_vertex);
					end
				end else begin
					want = expected_visits.pop_front();
					beats_checked++;
					if (result.visited_vertex !== want.visited_vertex ||
							result.last_vertex !== want.last_vertex) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: visit mismatch, expected vertex %0d last %0b, got vertex %0d last %0b",
								$time, want.visited_vertex, want.last_vertex,
								result.visited_vertex, result.last_vertex);
						end
					end
				end
			end
			if (cfg_we) begin
				model_count = cfg_wdata;
				settings_written++;
			end
			if (start && !busy) begin
				taken_cnt++;
				model_request(request);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run stopped after %0d cycles", $time, LIMIT_CYCLES);
		$display("adjacency_matrix_graph_traversal test failed");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		logic [CFG_W-1:0] n;
		int               roll;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sent_cnt = 0;
		taken_cnt = 0;
		hold_off = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		errors = 0;
		beats_checked = 0;
		depth_walks = 0;
		breadth_walks = 0;
		settings_written = 0;
		model_count = VERTEX_COUNT_RESET;
		foreach (graph_rows[i]) begin
			graph_rows[i] = '0;
		end

		// directed: empty walks, self edge, index extremes, removal, spare codes
		queue_setting(CFG_W'(ROW_W));
		queue_request(REQ_DFS, 0, 0);
		queue_request(REQ_BFS, 63, 63);
		queue_request(REQ_ADD_EDGE, 0, 63);
		queue_request(REQ_ADD_EDGE, 5, 5);
		queue_request(REQ_ADD_EDGE, 63, 62);
		queue_request(REQ_ADD_EDGE, 0, 1);
		queue_request(REQ_ADD_EDGE, 1, 2);
		queue_request(REQ_ADD_EDGE, 2, 0);
		queue_request(REQ_ADD_EDGE, 42, 21);
		queue_request(REQ_ADD_EDGE, 21, 63);
		queue_request(REQ_DFS, 0, 0);
		queue_request(REQ_BFS, 0, 63);
		queue_request(REQ_DFS, 5, 0);
		queue_request(REQ_REMOVE, 63, 0);
		queue_request(REQ_DFS, 0, 0);
		queue_request(REQ_BFS, 62, 0);
		for (int k = 1; k <= 3; k++) begin
			queue_request(REQ_CLEAR + REQ_W'(k), 63, 63);
		end
		queue_request(REQ_REMOVE, 5, 0);
		queue_request(REQ_BFS, 5, 0);
		queue_request(REQ_CLEAR, 0, 0);
		queue_request(REQ_DFS, 1, 0);

		// random phases, extremes of the vertex count among them
		phase_counts = '{7'd1, 7'd127, 7'd0, 7'd4, 7'd9, 7'd64, 7'd33,
			CFG_W'($urandom_range(1, 64)), 7'd100, 7'd16};
		foreach (phase_counts[p]) begin
			n = phase_counts[p];
			queue_setting(n);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 46) begin
					queue_request(REQ_ADD_EDGE, pick_vertex(n), pick_vertex(n));
				end else if (roll < 54) begin
					queue_request(REQ_REMOVE, pick_vertex(n), $urandom_range(0, 63));
				end else if (roll < 72) begin
					queue_request(REQ_DFS, pick_vertex(n), $urandom_range(0, 63));
				end else if (roll < 90) begin
					queue_request(REQ_BFS, pick_vertex(n), $urandom_range(0, 63));
				end else if (roll < 93) begin
					queue_request(REQ_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
				end else begin
					queue_request(REQ_CLEAR + REQ_W'($urandom_range(1, 3)),
						$urandom_range(0, 63), $urandom_range(0, 63));
				end
			end
		end

		// hold reset, then release it on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every beat to be taken and every visit to come back
		while (pending_beats.size() != 0 || start || busy || expected_visits.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d requests under %0d vertex count settings: %0d depth-first and %0d breadth-first walks",
			taken_cnt, settings_written, depth_walks, breadth_walks);
		$display("checked %0d visit beats, %0d mismatches", beats_checked, errors);
		if (errors == 0) begin
			$display("adjacency_matrix_graph_traversal test passed");
		end else begin
			$display("adjacency_matrix_graph_traversal test failed");
		end
		$finish;
	end

endmodule
